[rtl/core/http_request_head_parser_core_macros.svh]
// assertion macros for the request head parser core
// needs i_clk and i_rst_n in the scope of each use
`ifndef HTTP_REQUEST_HEAD_PARSER_CORE_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define HRHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hrhp_pkg.sv]
// shared types and constants of the request head parser core
// no dependencies
package hrhp_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
    localparam int OUT_POS_W    = 12;

    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [OUT_POS_W-1:0] t_out_pos;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_PATH,
        PH_QUERY,
        PH_PROTO,
        PH_HEADERS,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [3:0] {
        EV_METHOD_END  = 4'd0,
        EV_PATH_QUERY  = 4'd1,
        EV_PATH_END    = 4'd2,
        EV_QUERY_END   = 4'd3,
        EV_LINE_PATH   = 4'd4,
        EV_LINE_QUERY  = 4'd5,
        EV_LINE_PROTO  = 4'd6,
        EV_HEADER      = 4'd7,
        EV_HEAD_END    = 4'd8,
        EV_BAD_REQUEST = 4'd9
    } t_event;

    typedef struct packed {
        t_phase     phase;
        t_pos       pos;
        logic [7:0] prev_byte;
        logic [7:0] prev2_byte;
        t_pos       hdr_start;
        t_pos       key_start;
        t_pos       key_end;
        t_pos       val_start;
        logic       ks_vld;
        logic       ke_vld;
        logic       vs_vld;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:      PH_METHOD,
        pos:        '0,
        prev_byte:  '0,
        prev2_byte: '0,
        hdr_start:  '0,
        key_start:  '0,
        key_end:    '0,
        val_start:  '0,
        ks_vld:     1'b0,
        ke_vld:     1'b0,
        vs_vld:     1'b0
    };

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic     vld;
        t_event   ev;
        t_out_pos pos_a;
        t_out_pos pos_b;
        t_out_pos pos_c;
        t_out_pos pos_d;
    } t_result;

endpackage

[rtl/core/hrhp_ifs.sv]
// valid/ready channel interfaces of the request head parser core
// depends on hrhp_pkg
interface hrhp_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface hrhp_res_if;
    logic                           valid;
    logic                           ready;
    logic [3:0]                     event_res;
    logic [hrhp_pkg::OUT_POS_W-1:0] pos_a;
    logic [hrhp_pkg::OUT_POS_W-1:0] pos_b;
    logic [hrhp_pkg::OUT_POS_W-1:0] pos_c;
    logic [hrhp_pkg::OUT_POS_W-1:0] pos_d;

    modport source (output valid, output event_res, output pos_a, output pos_b,
                    output pos_c, output pos_d, input ready);
    modport sink   (input valid, input event_res, input pos_a, input pos_b,
                    input pos_c, input pos_d, output ready);
endinterface

[rtl/core/hrhp_in_reg.sv]
// input register stage: holds one request item ahead of the parse step
// depends on hrhp_pkg and hrhp_req_if
module hrhp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hrhp_req_if.sink          i_req,
    input  logic              i_adv,
    output logic              o_vld,
    output hrhp_pkg::t_item   o_item
);
    import hrhp_pkg::*;

    logic  r_vld;
    t_item r_item;

    // refill whenever empty or the held item moves on
    assign i_req.ready = !r_vld || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_item <= '{cmd: i_req.cmd, data_byte: i_req.data_byte};
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
endmodule

[rtl/core/hrhp_step.sv]
// per-byte parse step: next scanner state and result from state and item
// depends on hrhp_pkg
module hrhp_step (
    input  logic              i_go,
    input  hrhp_pkg::t_item   i_item,
    input  hrhp_pkg::t_state  i_state,
    output hrhp_pkg::t_state  o_state,
    output hrhp_pkg::t_result o_res
);
    import hrhp_pkg::*;

    logic [7:0] c;
    t_pos       p;
    logic       ovf;
    logic       halted;
    logic [7:0] lc;
    logic       head_end;
    logic       colon_take;
    logic       line_brk;
    t_pos       vend;
    t_pos       ks_eff;
    t_pos       ke_eff;
    t_pos       vs_eff;
    t_pos       vs_cur;

    // byte decode shared by state and result logic
    always_comb begin
        c          = i_item.data_byte;
        p          = i_state.pos;
        ovf        = (p >= t_pos'(BUFFER_BYTES));
        halted     = !(i_state.phase == PH_METHOD || i_state.phase == PH_PATH ||
                       i_state.phase == PH_QUERY  || i_state.phase == PH_PROTO ||
                       i_state.phase == PH_HEADERS);
        lc         = (p > i_state.hdr_start) ? i_state.prev_byte : 8'h00;
        head_end   = (c == CH_LF) && (lc == CH_CR) && (i_state.prev2_byte == CH_LF);
        colon_take = !i_state.ke_vld && (c == CH_COLON);
        line_brk   = (lc == CH_LF) && (c != CH_SP) && (c != CH_HT);
        vend       = p - t_pos'(2);
        ks_eff     = i_state.ks_vld ? i_state.key_start
                                    : ((lc == 8'h00) ? p : p - t_pos'(1));
        vs_cur     = (i_state.ke_vld && !i_state.vs_vld) ? p : i_state.val_start;
        ke_eff     = i_state.ke_vld ? i_state.key_end : vend;
        vs_eff     = i_state.ke_vld ? vs_cur : vend;
    end

    // next state
    always_comb begin
        o_state = i_state;
        if (i_go) begin
            if (i_item.cmd) begin
                o_state = STATE_RESET;
            end else if (!halted) begin
                if (ovf) begin
                    o_state.phase = PH_ERROR;
                end else begin
                    case (i_state.phase)
                        PH_METHOD: begin
                            if (c == CH_SP) begin
                                o_state.phase = PH_PATH;
                            end else if (c == CH_LF) begin
                                o_state.phase = PH_ERROR;
                            end
                        end
                        PH_PATH, PH_QUERY, PH_PROTO: begin
                            if (c == CH_LF) begin
                                o_state.phase     = PH_HEADERS;
                                o_state.hdr_start = p + t_pos'(1);
                                o_state.ks_vld    = 1'b0;
                                o_state.ke_vld    = 1'b0;
                                o_state.vs_vld    = 1'b0;
                            end else if (i_state.phase == PH_PATH && c == CH_QMARK) begin
                                o_state.phase = PH_QUERY;
                            end else if (i_state.phase != PH_PROTO && c == CH_SP) begin
                                o_state.phase = PH_PROTO;
                            end
                        end
                        PH_HEADERS: begin
                            if (head_end) begin
                                o_state.phase = PH_DONE;
                            end else begin
                                o_state.key_start = ks_eff;
                                o_state.ks_vld    = 1'b1;
                                if (colon_take) begin
                                    o_state.key_end = p;
                                    o_state.ke_vld  = 1'b1;
                                end else if (line_brk) begin
                                    o_state.key_end   = ke_eff;
                                    o_state.val_start = vs_eff;
                                    o_state.ks_vld    = 1'b0;
                                    o_state.ke_vld    = 1'b0;
                                    o_state.vs_vld    = 1'b0;
                                end else begin
                                    o_state.val_start = vs_cur;
                                    o_state.vs_vld    = i_state.vs_vld | i_state.ke_vld;
                                end
                            end
                        end
                        default: begin
                            o_state.phase = i_state.phase;
                        end
                    endcase
                    o_state.prev2_byte = i_state.prev_byte;
                    o_state.prev_byte  = c;
                    o_state.pos        = p + t_pos'(1);
                end
            end
        end
    end

    // result item
    always_comb begin
        o_res = '{vld: 1'b0, ev: EV_BAD_REQUEST, pos_a: '0, pos_b: '0,
                  pos_c: '0, pos_d: '0};
        if (i_go && !i_item.cmd && !halted) begin
            if (ovf) begin
                o_res.vld = 1'b1;
            end else begin
                case (i_state.phase)
                    PH_METHOD: begin
                        if (c == CH_SP) begin
                            o_res.vld   = 1'b1;
                            o_res.ev    = EV_METHOD_END;
                            o_res.pos_a = t_out_pos'(p);
                            o_res.pos_b = t_out_pos'(p + t_pos'(1));
                        end else if (c == CH_LF) begin
                            o_res.vld = 1'b1;
                        end
                    end
                    PH_PATH, PH_QUERY, PH_PROTO: begin
                        o_res.pos_a = t_out_pos'(p);
                        o_res.pos_b = t_out_pos'(p + t_pos'(1));
                        if (c == CH_LF) begin
                            o_res.vld   = 1'b1;
                            o_res.pos_a = t_out_pos'(p - t_pos'(1));
                            o_res.ev    = (i_state.phase == PH_PATH)  ? EV_LINE_PATH :
                                          (i_state.phase == PH_QUERY) ? EV_LINE_QUERY :
                                                                        EV_LINE_PROTO;
                        end else if (i_state.phase == PH_PATH && c == CH_QMARK) begin
                            o_res.vld = 1'b1;
                            o_res.ev  = EV_PATH_QUERY;
                        end else if (i_state.phase != PH_PROTO && c == CH_SP) begin
                            o_res.vld = 1'b1;
                            o_res.ev  = (i_state.phase == PH_PATH) ? EV_PATH_END
                                                                   : EV_QUERY_END;
                        end
                    end
                    PH_HEADERS: begin
                        if (head_end) begin
                            o_res.vld   = 1'b1;
                            o_res.ev    = EV_HEAD_END;
                            o_res.pos_a = t_out_pos'(p - t_pos'(1));
                            o_res.pos_b = t_out_pos'(p + t_pos'(1));
                        end else if (!colon_take && line_brk && (ks_eff < ke_eff)) begin
                            o_res.vld   = 1'b1;
                            o_res.ev    = EV_HEADER;
                            o_res.pos_a = t_out_pos'(ks_eff);
                            o_res.pos_b = t_out_pos'(ke_eff);
                            o_res.pos_c = t_out_pos'(vs_eff);
                            o_res.pos_d = t_out_pos'(vend);
                        end
                    end
                    default: begin
                        o_res.vld = 1'b0;
                    end
                endcase
            end
        end
    end
endmodule

[rtl/core/hrhp_out_reg.sv]
// result register stage: holds one result item until the sink takes it
// depends on hrhp_pkg and hrhp_res_if
module hrhp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hrhp_pkg::t_result i_res,
    output logic              o_free,
    hrhp_res_if.source        o_res
);
    import hrhp_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_free = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.vld) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid     = r_vld;
    assign o_res.event_res = r_res.ev;
    assign o_res.pos_a     = r_res.pos_a;
    assign o_res.pos_b     = r_res.pos_b;
    assign o_res.pos_c     = r_res.pos_c;
    assign o_res.pos_d     = r_res.pos_d;
endmodule

[rtl/core/http_request_head_parser_core.sv]
// http request head parser core: one request byte per item, boundary results out
// path: a byte item is held in the input register, its result item in the result register
// throughput: 1 item per cycle while the result register is free, set by the state update loop
// reset: i_rst_n synchronous active low, clears scanner state and both stage valids
// depends on hrhp_pkg, hrhp_ifs, hrhp_in_reg, hrhp_step, hrhp_out_reg and the macros
`include "http_request_head_parser_core_macros.svh"

module http_request_head_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrhp_req_if.sink   i_req,
    hrhp_res_if.source o_res
);
    import hrhp_pkg::*;

    // input stage outputs
    logic    w_item_vld;
    t_item   w_item;

    // step advances when the result register can take whatever it makes
    logic    w_out_free;
    logic    w_go;

    // scanner state, updated once per item
    t_state  r_state;
    t_state  n_state;
    t_result w_res;

    assign w_go = w_item_vld && w_out_free;

    // byte enters here and is held until the step advances
    hrhp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_adv   (w_go),
        .o_vld   (w_item_vld),
        .o_item  (w_item)
    );

    // all per-byte decisions are combinational off the held item and state
    hrhp_step u_step (
        .i_go    (w_go),
        .i_item  (w_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (w_res)
    );

    // state register, restart command is handled inside the step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    // result register decouples the sink from the step
    hrhp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_res   (o_res)
    );

    // bad request never carries a position
    `HRHP_ASSERT_NOW(a_bad_req_zero, o_res.valid && (o_res.event_res == EV_BAD_REQUEST), (o_res.pos_a == '0) && (o_res.pos_b == '0) && (o_res.pos_c == '0) && (o_res.pos_d == '0), "bad request item with nonzero position")

    // restart brings the scanner back to the start of a request
    `HRHP_ASSERT_NEXT(a_restart_clears, w_go && w_item.cmd, (r_state.phase == PH_METHOD) && (r_state.pos == '0) && !r_state.ks_vld, "restart did not clear scanner state")

    // a finished or failed request ignores data bytes
    `HRHP_ASSERT_NEXT(a_halt_sticks, w_go && !w_item.cmd && ((r_state.phase == PH_DONE) || (r_state.phase == PH_ERROR)), (r_state.phase == $past(r_state.phase)) && (r_state.pos == $past(r_state.pos)) && !o_res.valid, "data byte changed a halted scanner")

endmodule

[bench/http_request_head_parser_core_tb.sv]
// self-checking bench for the request head parser core: bytes in, boundary marks out
// depends on hrhp_pkg, hrhp_ifs and the parser core rtl
module http_request_head_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrhp_pkg::*;

    localparam int          RANDOM_ITEMS = 500;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          TAIL_CYCLES  = 10;

    // one boundary mark as the core reports it
    typedef struct packed {
        t_event   ev;
        t_out_pos pos_a;
        t_out_pos pos_b;
        t_out_pos pos_c;
        t_out_pos pos_d;
    } t_mark;

    localparam t_mark NO_MARK = '0;

    // directed row: typed rows carry their own mark, the others go through the scanner model
    typedef struct packed {
        bit         typed;
        logic       cmd;
        logic [7:0] data;
        bit         has;
        t_mark      m;
    } t_step;

    localparam t_step PLAN [29] = '{
        '{1'b1, 1'b1, 8'hFF,    1'b0, NO_MARK},                                 // restart
        '{1'b1, 1'b0, CH_LF,    1'b1, '{EV_BAD_REQUEST, 12'd0, 12'd0, 12'd0, 12'd0}},
        '{1'b1, 1'b0, 8'hFF,    1'b0, NO_MARK},                                 // dead after error
        '{1'b1, 1'b1, 8'h00,    1'b0, NO_MARK},                                 // restart
        '{1'b1, 1'b0, CH_SP,    1'b1, '{EV_METHOD_END, 12'd0, 12'd1, 12'd0, 12'd0}},
        '{1'b0, 1'b0, "/",      1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_QMARK, 1'b0, NO_MARK},
        '{1'b0, 1'b0, "q",      1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_SP,    1'b0, NO_MARK},
        '{1'b0, 1'b0, 8'hFF,    1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_LF,    1'b0, NO_MARK},
        '{1'b0, 1'b0, "k",      1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_COLON, 1'b0, NO_MARK},
        '{1'b0, 1'b0, "v",      1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_CR,    1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_LF,    1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_HT,    1'b0, NO_MARK},                                 // folded line
        '{1'b0, 1'b0, "w",      1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_CR,    1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_LF,    1'b0, NO_MARK},
        '{1'b0, 1'b0, 8'h00,    1'b0, NO_MARK},                                 // key, no colon yet
        '{1'b0, 1'b0, CH_CR,    1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_LF,    1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_COLON, 1'b0, NO_MARK},                                 // colon opens a line
        '{1'b0, 1'b0, CH_CR,    1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_LF,    1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_CR,    1'b0, NO_MARK},
        '{1'b0, 1'b0, CH_LF,    1'b0, NO_MARK},                                 // blank line, head end
        '{1'b1, 1'b0, "z",      1'b0, NO_MARK}                                  // dead after head end
    };

    // scanner state kept by the bench
    typedef struct {
        t_phase     ph;
        t_pos       pos;
        logic [7:0] prv;
        logic [7:0] prv2;
        t_pos       hdr0;
        t_pos       ks;
        t_pos       ke;
        t_pos       vs;
        logic       ks_ok;
        logic       ke_ok;
        logic       vs_ok;
    } t_scan;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    hrhp_req_if  req_ch ();
    hrhp_res_if  res_ch ();

    t_scan       scan;
    t_mark       marks_due [$];     // marks predicted and not yet seen
    logic [7:0]  req_bytes [$];     // bytes of the request being assembled
    bit          calm;              // no idling on either side for this request
    int          live_items;
    int          mismatches = 0;
    int unsigned cycles     = 0;

    http_request_head_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    initial forever #5 i_clk = ~i_clk;

    // hard stop if the core hangs or a mark never shows up
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // scanner model
    // ---------------------------------------------------------------------
    function automatic void scan_clear();
        scan.ph    = PH_METHOD;
        scan.pos   = '0;
        scan.prv   = '0;
        scan.prv2  = '0;
        scan.hdr0  = '0;
        scan.ks    = '0;
        scan.ke    = '0;
        scan.vs    = '0;
        scan.ks_ok = 1'b0;
        scan.ke_ok = 1'b0;
        scan.vs_ok = 1'b0;
    endfunction

    // positions fold to the 12-bit output width
    function automatic t_mark mark(t_event ev, t_pos a, t_pos b, t_pos c, t_pos d);
        t_mark m;
        m.ev    = ev;
        m.pos_a = a[OUT_POS_W-1:0];
        m.pos_b = b[OUT_POS_W-1:0];
        m.pos_c = c[OUT_POS_W-1:0];
        m.pos_d = d[OUT_POS_W-1:0];
        return m;
    endfunction

    // request line done at the LF in p, header scan starts right after it
    function automatic t_mark enter_headers(t_event ev, t_pos p);
        scan.ph    = PH_HEADERS;
        scan.hdr0  = p + 1'b1;
        scan.ks_ok = 1'b0;
        scan.ke_ok = 1'b0;
        scan.vs_ok = 1'b0;
        return mark(ev, p - 1'b1, p + 1'b1, '0, '0);
    endfunction

    function automatic bit scan_byte(input logic cmd, input logic [7:0] c, output t_mark m);
        t_pos       p;
        t_pos       vend;
        logic [7:0] lc;
        bit         hit;
        p   = scan.pos;
        hit = 1'b0;
        m   = NO_MARK;
        if (cmd) begin
            scan_clear();
            return 1'b0;
        end
        if (scan.ph inside {PH_DONE, PH_ERROR})
            return 1'b0;
        // byte beyond the buffer
        if (p >= BUFFER_BYTES) begin
            scan.ph = PH_ERROR;
            m = mark(EV_BAD_REQUEST, '0, '0, '0, '0);
            return 1'b1;
        end
        case (scan.ph)
            PH_METHOD: begin
                if (c == CH_SP) begin
                    scan.ph = PH_PATH;
                    hit = 1'b1;
                    m = mark(EV_METHOD_END, p, p + 1'b1, '0, '0);
                end else if (c == CH_LF) begin
                    scan.ph = PH_ERROR;
                    hit = 1'b1;
                    m = mark(EV_BAD_REQUEST, '0, '0, '0, '0);
                end
            end
            PH_PATH: begin
                if (c == CH_QMARK) begin
                    scan.ph = PH_QUERY;
                    hit = 1'b1;
                    m = mark(EV_PATH_QUERY, p, p + 1'b1, '0, '0);
                end else if (c == CH_SP) begin
                    scan.ph = PH_PROTO;
                    hit = 1'b1;
                    m = mark(EV_PATH_END, p, p + 1'b1, '0, '0);
                end else if (c == CH_LF) begin
                    hit = 1'b1;
                    m = enter_headers(EV_LINE_PATH, p);
                end
            end
            PH_QUERY: begin
                if (c == CH_SP) begin
                    scan.ph = PH_PROTO;
                    hit = 1'b1;
                    m = mark(EV_QUERY_END, p, p + 1'b1, '0, '0);
                end else if (c == CH_LF) begin
                    hit = 1'b1;
                    m = enter_headers(EV_LINE_QUERY, p);
                end
            end
            PH_PROTO: begin
                if (c == CH_LF) begin
                    hit = 1'b1;
                    m = enter_headers(EV_LINE_PROTO, p);
                end
            end
            default: begin
                // previous byte reads as zero on the first header byte
                lc = (p > scan.hdr0) ? scan.prv : 8'h00;
                if (c == CH_LF && lc == CH_CR && scan.prv2 == CH_LF) begin
                    scan.ph = PH_DONE;
                    hit = 1'b1;
                    m = mark(EV_HEAD_END, p - 1'b1, p + 1'b1, '0, '0);
                end else begin
                    if (!scan.ks_ok) begin
                        scan.ks    = (lc == 8'h00) ? p : p - 1'b1;
                        scan.ks_ok = 1'b1;
                    end
                    if (!scan.ke_ok && c == CH_COLON) begin
                        scan.ke    = p;
                        scan.ke_ok = 1'b1;
                    end else begin
                        if (scan.ke_ok && !scan.vs_ok) begin
                            scan.vs    = p;
                            scan.vs_ok = 1'b1;
                        end
                        // a new line that is not a fold closes the pending header
                        if (lc == CH_LF && c != CH_SP && c != CH_HT) begin
                            vend = p - 2'd2;
                            if (!scan.ke_ok) begin
                                scan.ke = vend;
                                scan.vs = vend;
                            end
                            if (scan.ks < scan.ke) begin
                                hit = 1'b1;
                                m = mark(EV_HEADER, scan.ks, scan.ke, scan.vs, vend);
                            end
                            scan.ks_ok = 1'b0;
                            scan.ke_ok = 1'b0;
                            scan.vs_ok = 1'b0;
                        end
                    end
                end
            end
        endcase
        scan.prv2 = scan.prv;
        scan.prv  = c;
        scan.pos  = p + 1'b1;
        return hit;
    endfunction

    // ---------------------------------------------------------------------
    // byte source
    // ---------------------------------------------------------------------

    // one item across the request channel, predicted at the accepting edge
    task automatic send(input logic cmd, input logic [7:0] b, output bit hit, output t_mark m);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= cmd;
        req_ch.data_byte <= b;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        // bytes swallowed after head end or error do not count
        if (cmd || !(scan.ph inside {PH_DONE, PH_ERROR}))
            live_items++;
        hit = scan_byte(cmd, b, m);
    endtask

    task automatic feed(input logic cmd, input logic [7:0] b);
        bit    hit;
        t_mark m;
        send(cmd, b, hit, m);
        if (hit)
            marks_due.push_back(m);
    endtask

    // hold the channel quiet until every predicted mark is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (marks_due.size() != 0) @(posedge i_clk);
    endtask

    // mostly printable, sometimes any byte, never one of the three delimiters
    function automatic logic [7:0] field_byte(logic [7:0] x, logic [7:0] y, logic [7:0] z);
        logic [7:0] b;
        do
            b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(33, 126));
        while (b == x || b == y || b == z);
        return b;
    endfunction

    function automatic void push_run(int lo, int hi, logic [7:0] x, logic [7:0] y,
                                     logic [7:0] z);
        repeat ($urandom_range(lo, hi))
            req_bytes.push_back(field_byte(x, y, z));
    endfunction

    // one request: well-formed with random content, now and then damaged or pure noise
    task automatic send_request();
        int  n;
        bit  restart;
        req_bytes.delete();
        calm    = ($urandom_range(0, 4) == 0);
        restart = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(5, 30))
                req_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            // request line
            push_run(0, 6, CH_SP, CH_LF, CH_SP);
            req_bytes.push_back(CH_SP);
            req_bytes.push_back("/");
            push_run(0, 8, CH_SP, CH_LF, CH_QMARK);
            if ($urandom_range(0, 1)) begin
                req_bytes.push_back(CH_QMARK);
                push_run(0, 8, CH_SP, CH_LF, CH_SP);
            end
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1))
                    req_bytes.push_back(CH_CR);
                req_bytes.push_back(CH_LF);
            end else begin
                req_bytes.push_back(CH_SP);
                push_run(0, 8, CH_LF, CH_CR, CH_LF);
                req_bytes.push_back(CH_CR);
                req_bytes.push_back(CH_LF);
            end
            // header lines
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 9) == 0) begin
                    req_bytes.push_back(CH_COLON);
                end else begin
                    push_run(0, 6, CH_COLON, CH_CR, CH_LF);
                    if ($urandom_range(0, 9) != 0)
                        req_bytes.push_back(CH_COLON);
                end
                if ($urandom_range(0, 1))
                    req_bytes.push_back(CH_SP);
                push_run(0, 8, CH_CR, CH_LF, CH_CR);
                req_bytes.push_back(CH_CR);
                req_bytes.push_back(CH_LF);
                if ($urandom_range(0, 4) == 0) begin
                    req_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_HT);
                    push_run(1, 5, CH_CR, CH_LF, CH_CR);
                    req_bytes.push_back(CH_CR);
                    req_bytes.push_back(CH_LF);
                end
            end
            req_bytes.push_back(CH_CR);
            req_bytes.push_back(CH_LF);
            // damage: flipped bytes, cut short, junk after the end
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 3))
                    req_bytes[$urandom_range(0, req_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(0, req_bytes.size() - 1);
                while (req_bytes.size() > n)
                    void'(req_bytes.pop_back());
            end
            if ($urandom_range(0, 14) == 0)
                repeat ($urandom_range(1, 4))
                    req_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (restart)
            feed(1'b1, 8'($urandom_range(0, 255)));
        foreach (req_bytes[i])
            feed(1'b0, req_bytes[i]);
    endtask

    // ---------------------------------------------------------------------
    // mark sink and checker
    // ---------------------------------------------------------------------
    function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    initial begin
        int    stall;
        t_mark want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            if (marks_due.size() == 0) begin
                $error("result item with nothing expected: event_res %0d pos_a %0d",
                       res_ch.event_res, res_ch.pos_a);
                mismatches++;
            end else begin
                want = marks_due.pop_front();
                check_field("event_res", 12'(want.ev), 12'(res_ch.event_res));
                check_field("pos_a", want.pos_a, res_ch.pos_a);
                check_field("pos_b", want.pos_b, res_ch.pos_b);
                check_field("pos_c", want.pos_c, res_ch.pos_c);
                check_field("pos_d", want.pos_d, res_ch.pos_d);
            end
        end
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin
        bit    hit;
        t_mark m;
        req_ch.valid     <= 1'b0;
        req_ch.cmd       <= 1'b0;
        req_ch.data_byte <= 8'h00;
        res_ch.ready     <= 1'b0;
        calm = 1'b0;
        live_items = 0;
        scan_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk: errors, method end, path query, query end and proto line events, headers, folds, head end
        foreach (PLAN[i]) begin
            send(PLAN[i].cmd, PLAN[i].data, hit, m);
            if (PLAN[i].typed) begin
                if (PLAN[i].has)
                    marks_due.push_back(PLAN[i].m);
            end else if (hit) begin
                marks_due.push_back(m);
            end
        end
        drain();

        // long path: marks at the top of the position range, then buffer overflow
        feed(1'b1, 8'($urandom_range(0, 255)));
        feed(1'b0, "G");
        feed(1'b0, "E");
        feed(1'b0, "T");
        feed(1'b0, CH_SP);
        for (int i = 4; i < 4093; i++)
            feed(1'b0, field_byte(CH_SP, CH_LF, CH_QMARK));
        feed(1'b0, CH_QMARK);
        feed(1'b0, field_byte(CH_SP, CH_LF, CH_SP));
        feed(1'b0, CH_SP);                      // query end at 4095, next field wraps to 0
        feed(1'b0, field_byte(CH_SP, CH_LF, CH_SP));
        feed(1'b0, 8'($urandom_range(0, 255)));
        drain();

        // long header value, head end on the last byte of the buffer
        feed(1'b1, 8'($urandom_range(0, 255)));
        feed(1'b0, "G");
        feed(1'b0, CH_SP);
        feed(1'b0, "/");
        feed(1'b0, CH_SP);
        feed(1'b0, CH_LF);
        feed(1'b0, "k");
        feed(1'b0, CH_COLON);
        for (int i = 7; i < 4092; i++)
            feed(1'b0, field_byte(CH_CR, CH_LF, CH_CR));
        feed(1'b0, CH_CR);
        feed(1'b0, CH_LF);
        feed(1'b0, CH_CR);
        feed(1'b0, CH_LF);
        feed(1'b0, 8'($urandom_range(0, 255)));
        drain();

        // random requests, with an occasional full pause
        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            send_request();
            if ($urandom_range(0, 24) == 0)
                drain();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
